// ----- design/vsm_pkg.sv -----
// Shared types, constants and states for the vector similarity metric core.
// Depends on nothing; the datapath, controller and top level import it.
package vsm_pkg;
	localparam int MAX_DIM    = 4096;
	localparam int ELEM_WIDTH = 16;
	localparam int DOT_W      = 44;
	localparam int NORM_W     = 43;
	localparam int DIFF_W     = 45;
	localparam int VALUE_W    = 46;
	localparam int PROD_W     = 86;
	localparam int ROOT_W     = 43;
	localparam int QUOT_W     = 16;
	localparam int MUL_HW     = 22;

	localparam logic signed [DOT_W-1:0] DOT_LIM =
		DOT_W'(longint'(MAX_DIM) * (longint'(1) << (2*ELEM_WIDTH-2)));
	localparam logic [NORM_W-1:0] NORM_LIM =
		NORM_W'(longint'(MAX_DIM) * (longint'(1) << (2*ELEM_WIDTH-2)));
	localparam logic [DIFF_W-1:0] DIFF_LIM =
		DIFF_W'(longint'(MAX_DIM) * ((longint'(1) << ELEM_WIDTH) - 1)
			* ((longint'(1) << ELEM_WIDTH) - 1));

	typedef enum logic [1:0] {
		METRIC_DOT  = 2'd0,
		METRIC_COS  = 2'd1,
		METRIC_L2SQ = 2'd2,
		METRIC_NONE = 2'd3
	} metric_t;

	typedef enum logic [2:0] {
		ST_ACC, ST_MSTART, ST_MUL, ST_SQRT, ST_DIV, ST_OUT
	} state_t;

	typedef struct packed {
		logic acc_en;    // add the incoming pair
		logic clear;     // clear accumulators after capture
		logic capture;   // latch result value/flag into output reg
		logic mul_start; // begin norm product
		logic sqrt_step;
		logic div_start;
		logic div_step;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic sqrt_done;
		logic div_done;
	} sts_t;
endpackage

// ----- design/vsm_datapath.sv -----
// Datapath: saturating accumulators, norm product, iterative root and divider.
// Depends on vsm_pkg.
module vsm_datapath import vsm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic signed [ELEM_WIDTH-1:0] elem_a,
	input  logic signed [ELEM_WIDTH-1:0] elem_b,
	input  metric_t                   metric,
	output logic signed [VALUE_W-1:0] res_value,
	output logic                      res_sat
);
	logic signed [DOT_W-1:0] dot_q;
	logic [NORM_W-1:0] na_q, nb_q;
	logic [DIFF_W-1:0] df_q;
	logic sat_q;

	logic signed [2*ELEM_WIDTH-1:0] pab, paa, pbb;
	logic signed [ELEM_WIDTH:0] d;
	logic [2*ELEM_WIDTH+1:0] pdd;
	logic signed [DOT_W:0] dot_n;
	logic [NORM_W:0] na_n, nb_n;
	logic [DIFF_W:0] df_n;
	logic signed [DOT_W-1:0] dot_c;
	logic [NORM_W-1:0] na_c, nb_c;
	logic [DIFF_W-1:0] df_c;
	logic sat_c;

	always_comb begin
		pab = elem_a * elem_b;
		paa = elem_a * elem_a;
		pbb = elem_b * elem_b;
		d = (ELEM_WIDTH+1)'(elem_a) - (ELEM_WIDTH+1)'(elem_b);
		pdd = $unsigned((2*ELEM_WIDTH+2)'(d) * (2*ELEM_WIDTH+2)'(d));
		dot_n = (DOT_W+1)'(dot_q) + (DOT_W+1)'(pab);
		na_n = (NORM_W+1)'(na_q) + (NORM_W+1)'($unsigned(paa));
		nb_n = (NORM_W+1)'(nb_q) + (NORM_W+1)'($unsigned(pbb));
		df_n = (DIFF_W+1)'(df_q) + (DIFF_W+1)'(pdd);
		sat_c = sat_q;
		if (dot_n > (DOT_W+1)'(DOT_LIM)) begin
			dot_c = DOT_LIM; sat_c = 1'b1;
		end else if (dot_n < -(DOT_W+1)'(DOT_LIM)) begin
			dot_c = -DOT_LIM; sat_c = 1'b1;
		end else dot_c = dot_n[DOT_W-1:0];
		if (na_n > (NORM_W+1)'(NORM_LIM)) begin
			na_c = NORM_LIM; sat_c = 1'b1;
		end else na_c = na_n[NORM_W-1:0];
		if (nb_n > (NORM_W+1)'(NORM_LIM)) begin
			nb_c = NORM_LIM; sat_c = 1'b1;
		end else nb_c = nb_n[NORM_W-1:0];
		if (df_n > (DIFF_W+1)'(DIFF_LIM)) begin
			df_c = DIFF_LIM; sat_c = 1'b1;
		end else df_c = df_n[DIFF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0; na_q <= '0; nb_q <= '0; df_q <= '0; sat_q <= 1'b0;
		end else if (cmd.clear) begin
			dot_q <= '0; na_q <= '0; nb_q <= '0; df_q <= '0; sat_q <= 1'b0;
		end else if (cmd.acc_en) begin
			dot_q <= dot_c; na_q <= na_c; nb_q <= nb_c; df_q <= df_c; sat_q <= sat_c;
		end
	end

	// Norm product: 43x43 split into 22-bit halves, one partial per cycle.
	logic [1:0] mcnt_q;
	logic [PROD_W-1:0] prod_q;
	logic [MUL_HW-1:0] xa, xb;
	logic [2*MUL_HW-1:0] pp;
	logic [5:0] scnt_q;
	always_comb begin
		xa = mcnt_q[1] ? MUL_HW'(na_q[NORM_W-1:MUL_HW]) : na_q[MUL_HW-1:0];
		xb = mcnt_q[0] ? MUL_HW'(nb_q[NORM_W-1:MUL_HW]) : nb_q[MUL_HW-1:0];
		pp = xa * xb;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mcnt_q <= '0;
		else if (cmd.mul_start) mcnt_q <= 2'd1;
		else if (mcnt_q != 2'd0) mcnt_q <= mcnt_q + 2'd1;
	end
	// the product register doubles as the root's radicand, two bits per step
	always_ff @(posedge clk) begin
		if (cmd.mul_start) prod_q <= PROD_W'(pp);
		else if (mcnt_q != 2'd0)
			prod_q <= prod_q + (PROD_W'(pp) << (MUL_HW * (int'(mcnt_q[1]) + int'(mcnt_q[0]))));
		else if (cmd.sqrt_step && scnt_q != 6'd0)
			prod_q <= prod_q << 2;
	end
	assign sts.mul_done = (mcnt_q == 2'd3);

	// Restoring square root, one result bit per cycle.
	logic [PROD_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [PROD_W+1:0] trial;
	logic [PROD_W+1:0] remsh;
	always_comb begin
		remsh = {rem_q, prod_q[PROD_W-1 -: 2]};
		trial = remsh - (PROD_W+2)'({root_q, 2'b01});
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scnt_q <= '0;
		else if (sts.mul_done) scnt_q <= 6'(ROOT_W);
		else if (cmd.sqrt_step && scnt_q != 6'd0) scnt_q <= scnt_q - 6'd1;
	end
	always_ff @(posedge clk) begin
		if (sts.mul_done) begin
			rem_q <= '0; root_q <= '0;
		end else if (cmd.sqrt_step && scnt_q != 6'd0) begin
			if (!trial[PROD_W+1]) begin
				rem_q <= trial[PROD_W-1:0]; root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= remsh[PROD_W-1:0]; root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end
	assign sts.sqrt_done = (scnt_q == 6'd0);

	// Divider: |dot|<<15 / root, 16 quotient bits suffice (clamped to -32768..32767).
	logic [DOT_W+15:0] num_q;
	logic [ROOT_W+QUOT_W:0] drem_q;
	logic [QUOT_W:0] quo_q;
	logic [QUOT_W:0] big_q;
	logic neg_q;
	logic [ROOT_W+QUOT_W+1:0] dtr;
	logic [ROOT_W+QUOT_W:0] dsh;
	always_comb begin
		dsh = {drem_q[ROOT_W+QUOT_W-1:0], num_q[DOT_W+15-1]};
		dtr = (ROOT_W+QUOT_W+2)'(dsh) - (ROOT_W+QUOT_W+2)'(root_q);
	end
	logic [6:0] dstep_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dstep_q <= '0;
		else if (cmd.div_start) dstep_q <= 7'(DOT_W+15);
		else if (cmd.div_step && dstep_q != 7'd0) dstep_q <= dstep_q - 7'd1;
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= dot_q[DOT_W-1];
			num_q <= {(dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q)), 15'd0};
			drem_q <= '0; quo_q <= '0; big_q <= '0;
		end else if (cmd.div_step && dstep_q != 7'd0) begin
			num_q <= {num_q[DOT_W+15-2:0], 1'b0};
			if (!dtr[ROOT_W+QUOT_W+1]) begin
				drem_q <= dtr[ROOT_W+QUOT_W:0];
				big_q <= big_q | quo_q[QUOT_W:QUOT_W];
				quo_q <= {quo_q[QUOT_W-1:0], 1'b1};
			end else begin
				drem_q <= dsh;
				big_q <= big_q | quo_q[QUOT_W:QUOT_W];
				quo_q <= {quo_q[QUOT_W-1:0], 1'b0};
			end
		end
	end
	assign sts.div_done = (dstep_q == 7'd0);

	logic signed [VALUE_W-1:0] cosv;
	always_comb begin
		if (root_q == '0) cosv = '0;
		else if (neg_q) cosv = (big_q != '0 || quo_q > 17'd32768) ? -VALUE_W'(32768)
			: -VALUE_W'(quo_q);
		else cosv = (big_q != '0 || quo_q > 17'd32767) ? VALUE_W'(32767) : VALUE_W'(quo_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_sat <= sat_q;
			unique case (metric)
				METRIC_DOT:  res_value <= VALUE_W'(dot_q);
				METRIC_COS:  res_value <= cosv;
				METRIC_L2SQ: res_value <= VALUE_W'(df_q);
				default:     res_value <= '0;
			endcase
		end
	end
endmodule

// ----- design/vsm_ctrl.sv -----
// Controller state machine sequencing accumulate, for cosine product, root and divide, then output.
// Depends on vsm_pkg.
module vsm_ctrl import vsm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    in_last,
	input  metric_t metric,
	output logic    out_valid,
	input  logic    out_stall,
	output cmd_t    cmd,
	input  sts_t    sts
);
	state_t st_q, st_n;
	logic   ov_q, ov_n;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_ACC; ov_q <= 1'b0;
		end else begin
			st_q <= st_n; ov_q <= ov_n;
		end
	end
	assign out_valid = ov_q;
	always_comb begin
		st_n = st_q;
		ov_n = ov_q && out_stall;
		cmd = '0;
		in_stall = 1'b1;
		unique case (st_q)
			ST_ACC: begin
				in_stall = 1'b0;
				cmd.acc_en = in_valid;
				if (in_valid && in_last)
					st_n = (metric == METRIC_COS) ? ST_MSTART : ST_OUT;
			end
			// the norms now include the last pair
			ST_MSTART: begin
				cmd.mul_start = 1'b1; st_n = ST_MUL;
			end
			ST_MUL: if (sts.mul_done) st_n = ST_SQRT;
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_done) begin
					cmd.div_start = 1'b1; st_n = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) st_n = ST_OUT;
			end
			ST_OUT: if (!ov_q || !out_stall) begin
				cmd.capture = 1'b1; cmd.clear = 1'b1; ov_n = 1'b1; st_n = ST_ACC;
			end
			default: st_n = ST_ACC;
		endcase
	end
endmodule

// ----- design/vector_similarity_metric_core.sv -----
// Top level of the vector similarity metric core.
// Depends on vsm_pkg, vsm_ctrl and vsm_datapath.
//
// Accepts one Q4.12 element pair per cycle while input is not stalled and
// accumulates dot, both squared norms and squared difference with
// saturation. After the pair marked last the result enters an output
// register: for dot and squared L2 the last pair is added to the
// accumulators and then the result is captured, with input stalled
// meanwhile; cosine first runs a norm multiply, a 43-step root and a
// 59-step divide, with input stalled the whole time. A result still
// waiting in the output register holds off the next one and stalls input
// further. Write metric only while idle.
module vector_similarity_metric_core import vsm_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [ELEM_WIDTH-1:0] elem_a,
	input  logic signed [ELEM_WIDTH-1:0] elem_b,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [VALUE_W-1:0]    value,
	output logic                         saturated
);
	metric_t metric_q;
	cmd_t    cmd;
	sts_t    sts;
	// hold the selected metric between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) metric_q <= METRIC_DOT;
		else if (cfg_we) metric_q <= metric_t'(cfg_wdata);
	end
	vsm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_last(last), .metric(metric_q),
		.out_valid, .out_stall, .cmd, .sts
	);
	vsm_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .elem_a, .elem_b, .metric(metric_q),
		.res_value(value), .res_sat(saturated)
	);
endmodule

// ----- design/vsm_checker.sv -----
// Port-level checker for the vector similarity metric core, bound to the top.
// Depends on vector_similarity_metric_core ports only.
module vsm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic last,
	input logic out_valid,
	input logic out_stall,
	input logic [45:0] value
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value)) else $error("result dropped");
	a_nolast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last && !out_valid |=> !out_valid)
		else $error("result without last");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last |=> in_stall) else $error("input not held after last");
endmodule

bind vector_similarity_metric_core vsm_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .last, .out_valid, .out_stall, .value
);
